// ----- src/mlfq_pkg.sv -----
`default_nettype none
package mlfq_pkg;
	localparam int LevelsDef   = 8;
	localparam int CapacityDef = 64;
	localparam logic [15:0] ThreshReset = 16'd16;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FREE, ST_LINK, ST_GET, ST_OUT, ST_BOOST, ST_PUT
	} state_t;

	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	typedef struct packed {
		logic latch;
		logic put_commit;
		logic get_commit;
		logic rd_free;
		logic rd_head;
		logic reject;
		logic splice;
	} cmd_t;

	typedef struct packed {
		logic is_get;
		logic full;
		logic empty;
		logic boost;
		logic splice_last;
	} sts_t;
endpackage
`default_nettype wire

// ----- src/mlfq_ready_queue_with_boost.sv -----
// Multilevel ready queue with periodic promotion. Each request (tuser: op; tdata: proc_id,
// priority_req) yields one result. A plain put or get runs through these steps from acceptance
// to the result handshake: accept, memory read of the free chain or level head, commit, then
// the result is offered and held until the output takes it. One request is in flight at a
// time, as the linked-list store is shared. A put that triggers a boost first splices the
// lower levels onto the top one level per cycle and then commits. A put to a full store is
// rejected. Slots are handed out first by a fill count, then from the free chain, so no
// clearing pass is needed after reset.
`default_nettype none
module mlfq_ready_queue_with_boost #(
	parameter int LEVELS   = mlfq_pkg::LevelsDef,
	parameter int CAPACITY = mlfq_pkg::CapacityDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata, // proc_id, priority_req
	input  wire logic        s_tuser, // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata  // out_id, out_valid, put_rejected, boosted
);
	mlfq_pkg::cmd_t cmd;
	mlfq_pkg::sts_t sts;
	logic [7:0] out_id;
	logic out_valid, put_rejected, boosted;

	assign cfg_ready = 1'b1;
	assign m_tdata = {5'd0, boosted, put_rejected, out_valid, out_id};

	mlfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
	);

	mlfq_dp #(.LEVELS(LEVELS), .CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_data(cfg_data), .cfg_we(cfg_valid),
		.in_op(s_tuser), .in_id(s_tdata[7:0]), .in_pri(s_tdata[11:8]),
		.cmd(cmd), .sts(sts), .out_id(out_id), .out_valid(out_valid),
		.put_rejected(put_rejected), .boosted(boosted)
	);
endmodule
`default_nettype wire

// ----- src/mlfq_ctrl.sv -----
`default_nettype none
module mlfq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire mlfq_pkg::sts_t sts,
	output mlfq_pkg::cmd_t      cmd
);
	mlfq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlfq_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			mlfq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d = mlfq_pkg::ST_FREE;
				end
			end
			mlfq_pkg::ST_FREE: begin
				if (sts.is_get) begin
					cmd.rd_head = 1'b1;
					state_d = mlfq_pkg::ST_GET;
				end else begin
					cmd.rd_free = 1'b1;
					state_d = mlfq_pkg::ST_LINK;
				end
			end
			mlfq_pkg::ST_LINK: begin
				priority if (sts.full) begin
					cmd.reject = 1'b1;
					state_d = mlfq_pkg::ST_OUT;
				end else if (sts.boost) begin
					state_d = mlfq_pkg::ST_BOOST;
				end else begin
					cmd.put_commit = 1'b1;
					state_d = mlfq_pkg::ST_OUT;
				end
			end
			// one lower level spliced onto the top per cycle
			mlfq_pkg::ST_BOOST: begin
				cmd.splice = 1'b1;
				if (sts.splice_last) state_d = mlfq_pkg::ST_PUT;
			end
			mlfq_pkg::ST_PUT: begin
				cmd.put_commit = 1'b1;
				state_d = mlfq_pkg::ST_OUT;
			end
			mlfq_pkg::ST_GET: begin
				if (!sts.empty) cmd.get_commit = 1'b1;
				state_d = mlfq_pkg::ST_OUT;
			end
			mlfq_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = mlfq_pkg::ST_IDLE;
			end
			default: state_d = mlfq_pkg::ST_IDLE;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mlfq_pkg::ST_OUT && !m_tready) |=> state_q == mlfq_pkg::ST_OUT)
		else $error("result dropped");
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.put_commit && cmd.get_commit)) else $error("double commit");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");
endmodule
`default_nettype wire

// ----- src/mlfq_dp.sv -----
`default_nettype none
module mlfq_dp #(
	parameter int LEVELS   = mlfq_pkg::LevelsDef,
	parameter int CAPACITY = mlfq_pkg::CapacityDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           cfg_we,
	input  wire logic           in_op,
	input  wire logic [7:0]     in_id,
	input  wire logic [3:0]     in_pri,
	input  wire mlfq_pkg::cmd_t cmd,
	output mlfq_pkg::sts_t      sts,
	output logic [7:0]          out_id,
	output logic                out_valid,
	output logic                put_rejected,
	output logic                boosted
);
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(LEVELS);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);
	localparam logic [LW-1:0] BL_START = LW'(LEVELS - 2);

	logic [7:0]    ids_mem [CAPACITY];
	logic [SW-1:0] link_mem [CAPACITY];
	logic [SW-1:0] heads_q [LEVELS];
	logic [SW-1:0] tails_q [LEVELS];
	logic [CW-1:0] cnt_q [LEVELS];
	logic [CW-1:0] used_q, fill_q;
	logic [SW-1:0] free_q;
	logic [15:0]   thr_q, pcnt_q;
	logic          op_q;
	logic [7:0]    id_q;
	logic [LW-1:0] lvl_q, glvl_q, bl_q;
	logic [SW-1:0] rd_link_q, rd_slot_q;
	logic [7:0]    rd_id_q;

	logic [LW-1:0] lvl_c, glvl_c;
	logic          any_c;
	logic [15:0]   pinc;
	logic          boost_c;

	always_comb begin
		if (in_pri == 4'd0) lvl_c = '0;
		else if (32'(in_pri) > LEVELS) lvl_c = TOP;
		else lvl_c = LW'(in_pri - 4'd1);
	end

	always_comb begin
		glvl_c = '0;
		any_c = 1'b0;
		for (int l = 0; l < LEVELS; l++)
			if (cnt_q[l] != '0) begin
				glvl_c = LW'(l);
				any_c = 1'b1;
			end
	end

	assign pinc = pcnt_q + 16'd1;
	assign boost_c = pinc >= thr_q;
	assign sts.is_get = op_q;
	assign sts.full = used_q == CW'(CAPACITY);
	assign sts.empty = used_q == '0;
	assign sts.boost = boost_c;
	assign sts.splice_last = bl_q == '0;

	// slot taken for a put: first-touch from fill counter, else free chain
	logic          fresh;
	logic [SW-1:0] put_slot;
	assign fresh = fill_q < CW'(CAPACITY);
	assign put_slot = fresh ? fill_q[SW-1:0] : free_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_op; id_q <= in_id; lvl_q <= lvl_c;
		end
		if (cmd.rd_free) rd_link_q <= link_mem[free_q];
		if (cmd.rd_head) begin
			glvl_q <= glvl_c;
			rd_slot_q <= heads_q[glvl_c];
			rd_id_q <= ids_mem[heads_q[glvl_c]];
			rd_link_q <= link_mem[heads_q[glvl_c]];
		end
		if (cmd.get_commit) link_mem[rd_slot_q] <= free_q;
		// old top tail links to the head of the level being spliced
		if (cmd.splice && cnt_q[bl_q] != '0 && cnt_q[TOP] != '0)
			link_mem[tails_q[TOP]] <= heads_q[bl_q];
		if (cmd.put_commit) begin
			ids_mem[put_slot] <= id_q;
			if (cnt_q[lvl_q] != '0) link_mem[tails_q[lvl_q]] <= put_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mlfq_pkg::ThreshReset;
			pcnt_q <= '0; used_q <= '0; fill_q <= '0; free_q <= '0;
			bl_q <= BL_START;
			out_id <= '0; out_valid <= 1'b0; put_rejected <= 1'b0; boosted <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				heads_q[l] <= '0; tails_q[l] <= '0; cnt_q[l] <= '0;
			end
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			if (cmd.latch) begin
				out_id <= '0; out_valid <= 1'b0; put_rejected <= 1'b0; boosted <= 1'b0;
			end
			if (cmd.reject) put_rejected <= 1'b1;
			if (cmd.splice) begin
				bl_q <= (bl_q == '0) ? BL_START : bl_q - LW'(1);
				if (cnt_q[bl_q] != '0) begin
					if (cnt_q[TOP] == '0) heads_q[TOP] <= heads_q[bl_q];
					tails_q[TOP] <= tails_q[bl_q];
					cnt_q[TOP] <= cnt_q[TOP] + cnt_q[bl_q];
					cnt_q[bl_q] <= '0; heads_q[bl_q] <= '0; tails_q[bl_q] <= '0;
				end
			end
			if (cmd.put_commit) begin
				used_q <= used_q + CW'(1);
				if (fresh) fill_q <= fill_q + CW'(1);
				else free_q <= rd_link_q;
				pcnt_q <= boost_c ? '0 : pinc;
				boosted <= boost_c;
				if (cnt_q[lvl_q] == '0) heads_q[lvl_q] <= put_slot;
				tails_q[lvl_q] <= put_slot;
				cnt_q[lvl_q] <= cnt_q[lvl_q] + CW'(1);
			end
			if (cmd.rd_head) begin
				out_valid <= any_c;
			end
			if (cmd.get_commit) begin
				out_id <= rd_id_q;
				used_q <= used_q - CW'(1);
				free_q <= rd_slot_q;
				cnt_q[glvl_q] <= cnt_q[glvl_q] - CW'(1);
				heads_q[glvl_q] <= (cnt_q[glvl_q] == CW'(1)) ? '0 : rd_link_q;
				if (cnt_q[glvl_q] == CW'(1)) tails_q[glvl_q] <= '0;
			end
		end
	end

	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY)) else $error("overfull");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= fill_q) else $error("used beyond fill");
	a_getok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.get_commit |-> cnt_q[glvl_q] != '0) else $error("get from empty level");
endmodule
`default_nettype wire
